[hw/rtl/ptq_pkg.sv]
package ptq_pkg;

  localparam int ID_W   = 4;
  localparam int MODE_W = 2;
  localparam int IVL_W  = 32;

  typedef enum logic [MODE_W-1:0] {
    MODE_ARM    = 2'd0,
    MODE_CANCEL = 2'd1,
    MODE_TICK   = 2'd2
  } ptq_mode_t;

  typedef enum logic [2:0] {
    OP_HOLD,
    OP_MARK,
    OP_COMPACT,
    OP_POP,
    OP_INSERT,
    OP_CLRFRESH
  } ptq_op_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_MARK,
    ST_COMPACT,
    ST_INSERT,
    ST_TCHK,
    ST_TINS
  } ptq_state_t;

  typedef struct packed {
    ptq_op_t           op;
    logic [ID_W-1:0]   id;
    logic              ins_fresh;
    logic [IVL_W-1:0]  ins_interval;
  } ptq_ctrl_t;

  typedef struct packed {
    logic              valid;
    logic              fresh;
    logic [ID_W-1:0]   id;
    logic [IVL_W-1:0]  interval;
  } ptq_meta_t;

  typedef struct packed {
    logic              fired;
    logic [ID_W-1:0]   id;
    logic              last;
    logic              any_pending;
  } ptq_res_t;

endpackage

[hw/rtl/ptq_cell.sv]
module ptq_cell
  import ptq_pkg::*;
#(
  parameter int TIME_BITS = 48
) (
  input  logic                 clk,
  input  logic                 rst_n,
  input  ptq_ctrl_t            ctrl,
  input  logic [TIME_BITS-1:0] ins_deadline,
  input  logic                 left_ins_before,
  input  ptq_meta_t            left_meta,
  input  logic [TIME_BITS-1:0] left_deadline,
  input  ptq_meta_t            right_meta,
  input  logic [TIME_BITS-1:0] right_deadline,
  output logic                 ins_before,
  output ptq_meta_t            meta,
  output logic [TIME_BITS-1:0] deadline
);

  ptq_meta_t            meta_r;
  ptq_meta_t            meta_nxt;
  logic [TIME_BITS-1:0] deadline_r;
  logic [TIME_BITS-1:0] deadline_nxt;

  // new entry goes ahead of this one; equal deadlines stay behind
  assign ins_before = !meta_r.valid || (ins_deadline < deadline_r);

  always_comb begin
    meta_nxt     = meta_r;
    deadline_nxt = deadline_r;
    unique case (ctrl.op)
      OP_HOLD: begin
      end
      OP_MARK: begin
        if (meta_r.valid && (meta_r.id == ctrl.id)) begin
          meta_nxt.valid = 1'b0;
        end
      end
      OP_COMPACT: begin
        // the hole moves one place towards the tail
        if (!meta_r.valid) begin
          meta_nxt     = right_meta;
          deadline_nxt = right_deadline;
        end else if (!left_meta.valid) begin
          meta_nxt.valid = 1'b0;
        end
      end
      OP_POP: begin
        meta_nxt     = right_meta;
        deadline_nxt = right_deadline;
      end
      OP_INSERT: begin
        if (ins_before) begin
          if (left_ins_before) begin
            meta_nxt     = left_meta;
            deadline_nxt = left_deadline;
          end else begin
            meta_nxt.valid    = 1'b1;
            meta_nxt.fresh    = ctrl.ins_fresh;
            meta_nxt.id       = ctrl.id;
            meta_nxt.interval = ctrl.ins_interval;
            deadline_nxt      = ins_deadline;
          end
        end
      end
      OP_CLRFRESH: begin
        meta_nxt.fresh = 1'b0;
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      meta_r.valid <= 1'b0;
      meta_r.fresh <= 1'b0;
    end else begin
      meta_r <= meta_nxt;
    end
  end

  always_ff @(posedge clk) begin
    deadline_r <= deadline_nxt;
  end

  assign meta     = meta_r;
  assign deadline = deadline_r;

endmodule

[hw/rtl/ptq_chain.sv]
module ptq_chain
  import ptq_pkg::*;
#(
  parameter int NUM_TIMERS = 16,
  parameter int TIME_BITS  = 48
) (
  input  logic                 clk,
  input  logic                 rst_n,
  input  ptq_ctrl_t            ctrl,
  input  logic [TIME_BITS-1:0] ins_deadline,
  output ptq_meta_t            head_meta,
  output logic [TIME_BITS-1:0] head_deadline
);

  ptq_meta_t            meta_a [NUM_TIMERS];
  logic [TIME_BITS-1:0] dl_a   [NUM_TIMERS];
  logic [NUM_TIMERS-1:0] ib_a;

  for (genvar i = 0; i < NUM_TIMERS; i++) begin : g_cell
    logic                 l_ib;
    ptq_meta_t            l_meta;
    logic [TIME_BITS-1:0] l_dl;
    ptq_meta_t            r_meta;
    logic [TIME_BITS-1:0] r_dl;

    if (i == 0) begin : g_head
      assign l_ib   = 1'b0;
      assign l_meta = '{valid: 1'b1, fresh: 1'b0, id: '0, interval: '0};
      assign l_dl   = '0;
    end else begin : g_mid
      assign l_ib   = ib_a[i-1];
      assign l_meta = meta_a[i-1];
      assign l_dl   = dl_a[i-1];
    end

    if (i == NUM_TIMERS - 1) begin : g_tail
      assign r_meta = '0;
      assign r_dl   = '0;
    end else begin : g_body
      assign r_meta = meta_a[i+1];
      assign r_dl   = dl_a[i+1];
    end

    ptq_cell #(
      .TIME_BITS(TIME_BITS)
    ) u_cell (
      .clk            (clk),
      .rst_n          (rst_n),
      .ctrl           (ctrl),
      .ins_deadline   (ins_deadline),
      .left_ins_before(l_ib),
      .left_meta      (l_meta),
      .left_deadline  (l_dl),
      .right_meta     (r_meta),
      .right_deadline (r_dl),
      .ins_before     (ib_a[i]),
      .meta           (meta_a[i]),
      .deadline       (dl_a[i])
    );
  end

  assign head_meta     = meta_a[0];
  assign head_deadline = dl_a[0];

endmodule

[hw/rtl/ptq_seq.sv]
module ptq_seq
  import ptq_pkg::*;
#(
  parameter int NUM_TIMERS = 16,
  parameter int TIME_BITS  = 48
) (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 in_valid,
  output logic                 in_ready,
  input  logic [MODE_W-1:0]    in_mode,
  input  logic [ID_W-1:0]      in_id,
  input  logic [TIME_BITS-1:0] in_deadline,
  input  logic [IVL_W-1:0]     in_interval,
  input  logic [TIME_BITS-1:0] in_now,
  output ptq_ctrl_t            ctrl,
  output logic [TIME_BITS-1:0] ins_deadline,
  input  ptq_meta_t            head_meta,
  input  logic [TIME_BITS-1:0] head_deadline,
  input  logic                 out_free,
  output logic                 res_valid,
  output ptq_res_t             res,
  output logic [TIME_BITS-1:0] res_deadline
);

  localparam int CNT_W = $clog2(NUM_TIMERS);
  localparam int SUM_W = ((TIME_BITS > IVL_W) ? TIME_BITS : IVL_W) + 1;

  ptq_state_t           state_r, state_nxt;
  logic [CNT_W-1:0]     cnt_r, cnt_nxt;
  logic [ID_W-1:0]      op_id_r, op_id_nxt;
  logic [TIME_BITS-1:0] op_deadline_r, op_deadline_nxt;
  logic [IVL_W-1:0]     op_interval_r, op_interval_nxt;
  logic [TIME_BITS-1:0] now_r, now_nxt;
  logic                 arm_r, arm_nxt;
  logic                 hold_valid_r, hold_valid_nxt;
  logic [ID_W-1:0]      hold_id_r, hold_id_nxt;

  logic                 id_ok;
  logic                 head_due;
  logic [SUM_W-1:0]     sum;
  logic [TIME_BITS-1:0] rearm_dl;

  assign id_ok    = (32'(in_id) < 32'(NUM_TIMERS));
  assign head_due = head_meta.valid && !head_meta.fresh && (head_deadline <= now_r);
  assign sum      = SUM_W'(now_r) + SUM_W'(head_meta.interval);
  assign rearm_dl = (sum[SUM_W-1:TIME_BITS] != '0) ? {TIME_BITS{1'b1}}
                                                     : sum[TIME_BITS-1:0];

  // next state
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      ST_IDLE: begin
        if (in_valid) begin
          unique case (ptq_mode_t'(in_mode))
            MODE_ARM, MODE_CANCEL: state_nxt = id_ok ? ST_MARK : ST_IDLE;
            MODE_TICK:             state_nxt = ST_TCHK;
            default:               state_nxt = ST_IDLE;
          endcase
        end
      end
      ST_MARK: state_nxt = ST_COMPACT;
      ST_COMPACT: begin
        if (cnt_r == CNT_W'(NUM_TIMERS - 2)) begin
          state_nxt = arm_r ? ST_INSERT : ST_IDLE;
        end
      end
      ST_INSERT: state_nxt = ST_IDLE;
      ST_TCHK: begin
        if (head_due) begin
          if (!hold_valid_r || out_free) begin
            state_nxt = (head_meta.interval != '0) ? ST_TINS : ST_TCHK;
          end
        end else if (out_free) begin
          state_nxt = ST_IDLE;
        end
      end
      ST_TINS: state_nxt = ST_TCHK;
      default: state_nxt = ST_IDLE;
    endcase
  end

  // outputs
  always_comb begin
    in_ready     = 1'b0;
    ctrl.op           = OP_HOLD;
    ctrl.id           = op_id_r;
    ctrl.ins_fresh    = 1'b0;
    ctrl.ins_interval = op_interval_r;
    ins_deadline = op_deadline_r;
    res_valid    = 1'b0;
    res          = '0;
    res_deadline = '0;
    unique case (state_r)
      ST_IDLE:    in_ready = 1'b1;
      ST_MARK:    ctrl.op = OP_MARK;
      ST_COMPACT: ctrl.op = OP_COMPACT;
      ST_INSERT:  ctrl.op = OP_INSERT;
      ST_TCHK: begin
        if (head_due) begin
          if (!hold_valid_r || out_free) begin
            ctrl.op   = OP_POP;
            res_valid = hold_valid_r;
            res.fired = 1'b1;
            res.id    = hold_id_r;
          end
        end else if (out_free) begin
          ctrl.op         = OP_CLRFRESH;
          res_valid       = 1'b1;
          res.fired       = hold_valid_r;
          res.id          = hold_valid_r ? hold_id_r : '0;
          res.last        = 1'b1;
          res.any_pending = head_meta.valid;
          res_deadline    = head_meta.valid ? head_deadline : '0;
        end
      end
      ST_TINS: begin
        ctrl.op        = OP_INSERT;
        ctrl.ins_fresh = 1'b1;
      end
      default: begin
      end
    endcase
  end

  // operand and hold registers
  always_comb begin
    cnt_nxt         = cnt_r;
    op_id_nxt       = op_id_r;
    op_deadline_nxt = op_deadline_r;
    op_interval_nxt = op_interval_r;
    now_nxt         = now_r;
    arm_nxt         = arm_r;
    hold_valid_nxt  = hold_valid_r;
    hold_id_nxt     = hold_id_r;
    unique case (state_r)
      ST_IDLE: begin
        if (in_valid) begin
          op_id_nxt       = in_id;
          op_deadline_nxt = in_deadline;
          op_interval_nxt = in_interval;
          now_nxt         = in_now;
          arm_nxt         = (ptq_mode_t'(in_mode) == MODE_ARM);
          hold_valid_nxt  = 1'b0;
        end
      end
      ST_MARK:    cnt_nxt = '0;
      ST_COMPACT: cnt_nxt = cnt_r + 1'b1;
      ST_TCHK: begin
        if (ctrl.op == OP_POP) begin
          hold_valid_nxt  = 1'b1;
          hold_id_nxt     = head_meta.id;
          op_id_nxt       = head_meta.id;
          op_interval_nxt = head_meta.interval;
          op_deadline_nxt = rearm_dl;
        end
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r      <= ST_IDLE;
      cnt_r        <= '0;
      arm_r        <= 1'b0;
      hold_valid_r <= 1'b0;
    end else begin
      state_r      <= state_nxt;
      cnt_r        <= cnt_nxt;
      arm_r        <= arm_nxt;
      hold_valid_r <= hold_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    op_id_r       <= op_id_nxt;
    op_deadline_r <= op_deadline_nxt;
    op_interval_r <= op_interval_nxt;
    now_r         <= now_nxt;
    hold_id_r     <= hold_id_nxt;
  end

endmodule

[hw/rtl/periodic_timer_queue.sv]
// Sorted timer queue for up to NUM_TIMERS timers kept in a row of cells, ordered by deadline
// with equal deadlines in arming order; the head cell always holds the earliest timer. On an
// arm or a cancel the old entry is cleared and the gap it leaves walks one cell per cycle to
// the tail; an arm then places the new entry. A tick pops due timers from the head cell one
// entry a cycle while the output word is free, and a periodic refire reinserts in the
// following cycle. The output word is registered, so a result may wait on out_tready while
// work goes on.
module periodic_timer_queue
  import ptq_pkg::*;
#(
  parameter int NUM_TIMERS = 16,
  parameter int TIME_BITS  = 48
) (
  input  logic                                    clk,
  input  logic                                    rst_n,
  input  logic                                    in_tvalid,
  output logic                                    in_tready,
  // timer_id, deadline, interval, now_time
  input  logic [((36+2*TIME_BITS+7)/8)*8-1:0]     in_tdata,
  // mode
  input  logic [MODE_W-1:0]                       in_tuser,
  output logic                                    out_tvalid,
  input  logic                                    out_tready,
  // fired_id, any_pending, next_deadline
  output logic [((5+TIME_BITS+7)/8)*8-1:0]        out_tdata,
  // fired
  output logic [0:0]                              out_tuser,
  output logic                                    out_tlast
);

  ptq_ctrl_t            ctrl;
  logic [TIME_BITS-1:0] ins_deadline;
  ptq_meta_t            head_meta;
  logic [TIME_BITS-1:0] head_deadline;
  logic                 out_free;
  logic                 res_valid;
  ptq_res_t             res;
  logic [TIME_BITS-1:0] res_deadline;

  logic                 out_valid_r, out_valid_nxt;
  ptq_res_t             out_res_r;
  logic [TIME_BITS-1:0] out_dl_r;

  ptq_seq #(
    .NUM_TIMERS(NUM_TIMERS),
    .TIME_BITS (TIME_BITS)
  ) u_seq (
    .clk          (clk),
    .rst_n        (rst_n),
    .in_valid     (in_tvalid),
    .in_ready     (in_tready),
    .in_mode      (in_tuser),
    .in_id        (in_tdata[ID_W-1:0]),
    .in_deadline  (in_tdata[ID_W +: TIME_BITS]),
    .in_interval  (in_tdata[ID_W+TIME_BITS +: IVL_W]),
    .in_now       (in_tdata[ID_W+TIME_BITS+IVL_W +: TIME_BITS]),
    .ctrl         (ctrl),
    .ins_deadline (ins_deadline),
    .head_meta    (head_meta),
    .head_deadline(head_deadline),
    .out_free     (out_free),
    .res_valid    (res_valid),
    .res          (res),
    .res_deadline (res_deadline)
  );

  ptq_chain #(
    .NUM_TIMERS(NUM_TIMERS),
    .TIME_BITS (TIME_BITS)
  ) u_chain (
    .clk          (clk),
    .rst_n        (rst_n),
    .ctrl         (ctrl),
    .ins_deadline (ins_deadline),
    .head_meta    (head_meta),
    .head_deadline(head_deadline)
  );

  // output word register
  assign out_free      = !out_valid_r || out_tready;
  assign out_valid_nxt = res_valid || (out_valid_r && !out_tready);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (res_valid) begin
      out_res_r <= res;
      out_dl_r  <= res_deadline;
    end
  end

  always_comb begin
    out_tdata                       = '0;
    out_tdata[ID_W-1:0]             = out_res_r.id;
    out_tdata[ID_W]                 = out_res_r.any_pending;
    out_tdata[ID_W+1 +: TIME_BITS]  = out_dl_r;
  end

  assign out_tvalid   = out_valid_r;
  assign out_tuser[0] = out_res_r.fired;
  assign out_tlast    = out_res_r.last;

endmodule
